[design/gae_pkg.sv]
// Shared types, constants and helper functions for the advantage scan unit.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gae_pkg;

    // Field widths of the stream words.
    localparam int ENV_W      = 6;
    localparam int VAL_W      = 32;
    localparam int WGT_W      = 17;
    localparam int ACC_W      = 32;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 72;

    // Width used to compare an environment index against the environment count.
    localparam int ENV_CMP_W  = 13;

    // Register file layout and reset values.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_DISCOUNT    = 1'b0;
    localparam logic REG_TRACE_DECAY = 1'b1;
    localparam logic [WGT_W-1:0] DISCOUNT_RESET    = 17'd64881;
    localparam logic [WGT_W-1:0] TRACE_DECAY_RESET = 17'd62259;

    // One in unsigned Q1.16.
    localparam logic [WGT_W-1:0] ONE_Q16 = 17'd65536;

    // Saturation bounds on a sign-extended 40-bit value.
    localparam logic signed [39:0] SAT_MAX = 40'sh00_7FFF_FFFF;
    localparam logic signed [39:0] SAT_MIN = 40'shFF_8000_0000;

    // Rounding constant for a half-up round of a Q32 product.
    localparam logic signed [65:0] HALF_Q32 = 66'sh0_8000_0000;

    typedef struct packed {
        logic [WGT_W-1:0] discount;
        logic [WGT_W-1:0] trace_decay;
    } cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0] val;
        logic             clip;
    } sat_t;

    // Weights above one are treated as one.
    function automatic logic [WGT_W-1:0] clamp_weight(input logic [WGT_W-1:0] w);
        clamp_weight = (w > ONE_Q16) ? ONE_Q16 : w;
    endfunction

    // Clip a signed value to the 32-bit range and flag the clip.
    function automatic sat_t sat32(input logic signed [39:0] x);
        sat_t r;
        if (x > SAT_MAX)
        begin
            r.val  = 32'h7FFF_FFFF;
            r.clip = 1'b1;
        end
        else if (x < SAT_MIN)
        begin
            r.val  = 32'h8000_0000;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = x[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/gae_advantage_scan_unit.sv]
// Each accepted input word yields one result word from the output register.
// Throughput: one word per cycle while environments differ and the result
// stream is not stalled; a word for an in-range environment that is still in
// the 5-stage read-modify-write path waits until its update is stored.
// Reset clears the pipeline, sets discount and trace decay to their defaults
// and marks every accumulator as zero at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module gae_advantage_scan_unit
    import gae_pkg::*;
#(
    parameter int ENVIRONMENTS = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: env_index, reward, value_estimate, next_value, bootstrap_weight,
    //        continue_weight (lowest bits first)
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: first_step
    input  wire logic                  s_axis_tuser,
    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: out_env_index, advantage, return_target, two zero pad bits
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: saturated
    output logic                       m_axis_tuser,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    // Only indices reachable by a 6-bit environment field need storage.
    localparam int MEM_DEPTH = (ENVIRONMENTS < 64) ? ENVIRONMENTS : 64;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    cfg_t              cfg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ACC_W-1:0]  rd_data;
    logic              rd_valid;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ACC_W-1:0]  wr_data;

    gae_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gae_acc_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    gae_scan_pipe #(
        .ENVIRONMENTS (ENVIRONMENTS),
        .ADDR_W       (ADDR_W)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_first  (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_sat   (m_axis_tuser),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rd_valid  (rd_valid),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

endmodule

`default_nettype wire

[design/gae_cfg_regs.sv]
// Configuration register file behind an APB-style port: discount and trace decay.
// Depends on gae_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module gae_cfg_regs
    import gae_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [WGT_W-1:0] discount_reg;
    logic [WGT_W-1:0] trace_decay_reg;
    logic             wr_strobe;
    logic             reg_index;

    // Registers sit on word addresses; bit 2 selects between them.
    assign reg_index = paddr[2];
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg    <= DISCOUNT_RESET;
            trace_decay_reg <= TRACE_DECAY_RESET;
        end
        else if (wr_strobe)
        begin
            unique case (reg_index)
                REG_DISCOUNT:    discount_reg    <= pwdata[WGT_W-1:0];
                REG_TRACE_DECAY: trace_decay_reg <= pwdata[WGT_W-1:0];
                default:         discount_reg    <= discount_reg;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (reg_index)
            REG_DISCOUNT:    prdata = {{(CFG_DATA_W-WGT_W){1'b0}}, discount_reg};
            REG_TRACE_DECAY: prdata = {{(CFG_DATA_W-WGT_W){1'b0}}, trace_decay_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.discount    = discount_reg;
    assign cfg.trace_decay = trace_decay_reg;

endmodule

`default_nettype wire

[design/gae_acc_mem.sv]
// Accumulator store: one-port-write, one-port-read memory with registered read
// data, plus a written flag per entry, returned with the read data, so unwritten entries can be taken as zero.
// Depends on gae_pkg for the accumulator width.
`timescale 1ns / 1ps
`default_nettype none

module gae_acc_mem
    import gae_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [ACC_W-1:0]  rd_data,
    output logic                   rd_valid,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [ACC_W-1:0]  wr_data
);

    logic [ACC_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [ACC_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    // Storage array and read port; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Written flags, cleared by reset so that every accumulator starts at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

[design/gae_scan_pipe.sv]
// Six-stage datapath of the advantage scan: weight products, delta, decay
// factor, carried accumulator, saturation and return. Reads and writes the
// accumulator store and holds off an environment that is still in flight.
// Depends on gae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gae_scan_pipe
    import gae_pkg::*;
#(
    parameter int ENVIRONMENTS = 64,
    parameter int ADDR_W       = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic                  in_first,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [OUT_DATA_W-1:0] out_data,
    output logic                       out_sat,
    output logic                       rd_en,
    output logic      [ADDR_W-1:0]     rd_addr,
    input  wire logic [ACC_W-1:0]      rd_data,
    input  wire logic                  rd_valid,
    output logic                       wr_en,
    output logic      [ADDR_W-1:0]     wr_addr,
    output logic      [ACC_W-1:0]      wr_data
);

    localparam logic [ENV_CMP_W-1:0] ENV_LIMIT = ENV_CMP_W'(ENVIRONMENTS);

    // Input word fields.
    logic [ENV_W-1:0] env_in;
    logic [VAL_W-1:0] reward_in;
    logic [VAL_W-1:0] value_in;
    logic [VAL_W-1:0] next_in;
    logic [WGT_W-1:0] boot_w;
    logic [WGT_W-1:0] cont_w;
    logic [WGT_W-1:0] gamma;
    logic [WGT_W-1:0] lambda;
    logic [33:0]      gw_full;
    logic [33:0]      gl_full;
    logic             in_range;
    logic             hazard;
    logic             accept;

    // Stage enables.
    logic en1, en2, en3, en4, en5, en6;

    // Stage 1: weight products.
    logic             v1_reg, wr1_reg, use1_reg;
    logic [ENV_W-1:0] env1_reg;
    logic [VAL_W-1:0] reward1_reg, value1_reg, next1_reg;
    logic [32:0]      gw1_reg, gl1_reg;
    logic [WGT_W-1:0] cw1_reg;

    // Stage 2: bootstrap product, decay product, old accumulator.
    logic               v2_reg, wr2_reg;
    logic [ENV_W-1:0]   env2_reg;
    logic [VAL_W-1:0]   reward2_reg, value2_reg;
    logic [ACC_W-1:0]   acc_old2_reg;
    logic signed [65:0] bprod2_reg;
    logic [48:0]        kp2_reg;
    logic signed [65:0] bprod_c;
    logic [49:0]        kp_full;

    // Stage 3: delta and rounded decay factor.
    logic               v3_reg, wr3_reg;
    logic [ENV_W-1:0]   env3_reg;
    logic [VAL_W-1:0]   value3_reg;
    logic [ACC_W-1:0]   acc_old3_reg;
    logic signed [35:0] delta3_reg;
    logic [32:0]        k3_reg;
    logic signed [65:0] bsum_c;
    logic signed [35:0] delta_c;
    logic [49:0]        ksum_c;

    // Stage 4: carried accumulator product.
    logic               v4_reg, wr4_reg;
    logic [ENV_W-1:0]   env4_reg;
    logic [VAL_W-1:0]   value4_reg;
    logic signed [35:0] delta4_reg;
    logic signed [65:0] cprod4_reg;
    logic signed [65:0] cprod_c;

    // Stage 5: new accumulator, written back as it leaves.
    logic               v5_reg, wr5_reg, sat5_reg;
    logic [ENV_W-1:0]   env5_reg;
    logic [VAL_W-1:0]   value5_reg;
    logic [ACC_W-1:0]   acc5_reg;
    logic signed [65:0] csum_c;
    logic signed [36:0] sum_c;
    sat_t               acc_sat;

    // Stage 6: output register with the return target.
    logic               v6_reg, sat6_reg;
    logic [ENV_W-1:0]   env6_reg;
    logic [ACC_W-1:0]   adv6_reg, ret6_reg;
    logic signed [32:0] ret_c;
    sat_t               ret_sat;

    // Unpack the input word and clamp the weights.
    assign env_in    = in_data[5:0];
    assign reward_in = in_data[37:6];
    assign value_in  = in_data[69:38];
    assign next_in   = in_data[101:70];
    assign boot_w    = clamp_weight(in_data[118:102]);
    assign cont_w    = clamp_weight(in_data[135:119]);
    assign gamma     = clamp_weight(cfg.discount);
    assign lambda    = clamp_weight(cfg.trace_decay);
    assign gw_full   = {17'd0, gamma} * {17'd0, boot_w};
    assign gl_full   = {17'd0, gamma} * {17'd0, lambda};
    assign in_range  = {{(ENV_CMP_W-ENV_W){1'b0}}, env_in} < ENV_LIMIT;

    // A stage moves when it is empty or the stage after it moves.
    assign en6 = !v6_reg || out_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    // Interlock: an in-range environment is held off until its pending update is stored.
    assign hazard = (v1_reg && wr1_reg && (env1_reg == env_in))
                 || (v2_reg && wr2_reg && (env2_reg == env_in))
                 || (v3_reg && wr3_reg && (env3_reg == env_in))
                 || (v4_reg && wr4_reg && (env4_reg == env_in))
                 || (v5_reg && wr5_reg && (env5_reg == env_in));

    assign in_ready = en1 && !hazard;
    assign accept   = in_valid && in_ready;
    assign rd_en    = accept;
    assign rd_addr  = env_in[ADDR_W-1:0];

    // Valid flags of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= accept;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    // Stage arithmetic.
    assign bprod_c = $signed({{34{next1_reg[VAL_W-1]}}, next1_reg})
                   * $signed({33'd0, gw1_reg});
    assign kp_full = {17'd0, gl1_reg} * {33'd0, cw1_reg};

    assign bsum_c  = bprod2_reg + HALF_Q32;
    assign delta_c = $signed({{4{reward2_reg[VAL_W-1]}}, reward2_reg})
                   + $signed({{2{bsum_c[65]}}, bsum_c[65:32]})
                   - $signed({{4{value2_reg[VAL_W-1]}}, value2_reg});
    assign ksum_c  = {1'b0, kp2_reg} + 50'd32768;

    assign cprod_c = $signed({{34{acc_old3_reg[ACC_W-1]}}, acc_old3_reg})
                   * $signed({33'd0, k3_reg});

    assign csum_c  = cprod4_reg + HALF_Q32;
    assign sum_c   = $signed({delta4_reg[35], delta4_reg})
                   + $signed({{3{csum_c[65]}}, csum_c[65:32]});
    assign acc_sat = sat32({{3{sum_c[36]}}, sum_c});

    assign ret_c   = $signed({acc5_reg[ACC_W-1], acc5_reg})
                   + $signed({value5_reg[VAL_W-1], value5_reg});
    assign ret_sat = sat32({{7{ret_c[32]}}, ret_c});

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            env1_reg    <= env_in;
            wr1_reg     <= in_range;
            use1_reg    <= in_range && !in_first;
            reward1_reg <= reward_in;
            value1_reg  <= value_in;
            next1_reg   <= next_in;
            gw1_reg     <= gw_full[32:0];
            gl1_reg     <= gl_full[32:0];
            cw1_reg     <= cont_w;
        end
        if (en2)
        begin
            env2_reg     <= env1_reg;
            wr2_reg      <= wr1_reg;
            reward2_reg  <= reward1_reg;
            value2_reg   <= value1_reg;
            acc_old2_reg <= (use1_reg && rd_valid) ? rd_data : '0;
            bprod2_reg   <= bprod_c;
            kp2_reg      <= kp_full[48:0];
        end
        if (en3)
        begin
            env3_reg     <= env2_reg;
            wr3_reg      <= wr2_reg;
            value3_reg   <= value2_reg;
            acc_old3_reg <= acc_old2_reg;
            delta3_reg   <= delta_c;
            k3_reg       <= ksum_c[48:16];
        end
        if (en4)
        begin
            env4_reg   <= env3_reg;
            wr4_reg    <= wr3_reg;
            value4_reg <= value3_reg;
            delta4_reg <= delta3_reg;
            cprod4_reg <= cprod_c;
        end
        if (en5)
        begin
            env5_reg   <= env4_reg;
            wr5_reg    <= wr4_reg;
            value5_reg <= value4_reg;
            acc5_reg   <= acc_sat.val;
            sat5_reg   <= acc_sat.clip;
        end
        if (en6)
        begin
            env6_reg <= env5_reg;
            adv6_reg <= acc5_reg;
            ret6_reg <= ret_sat.val;
            sat6_reg <= sat5_reg || ret_sat.clip;
        end
    end

    // Write back the new accumulator as the item leaves stage 5.
    assign wr_en   = v5_reg && wr5_reg && en6;
    assign wr_addr = env5_reg[ADDR_W-1:0];
    assign wr_data = acc5_reg;

    assign out_valid = v6_reg;
    assign out_data  = {2'b00, ret6_reg, adv6_reg, env6_reg};
    assign out_sat   = sat6_reg;

endmodule

`default_nettype wire

[design/gae_scan_checker.sv]
// Port-level checks for the advantage scan unit, bound to the top level.
// Depends on gae_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module gae_scan_checker
    import gae_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tuser,
    input wire logic [CFG_DATA_W-1:0] prdata,
    input wire logic                  pready
);

    // A stalled result word holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Nothing is produced right after reset is released.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result word present straight out of reset");

    // The configuration port never inserts wait states.
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    // Registers are 17 bits wide; upper read bits stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        prdata[CFG_DATA_W-1:WGT_W] == '0)
        else $error("register read returned bits above the register width");

    // Padding bits of a result word are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:70] == '0)
        else $error("result padding bits not zero");

endmodule

bind gae_advantage_scan_unit gae_scan_checker u_scan_checker (.*);

`default_nettype wire

[tb/gae_advantage_scan_unit_tb.sv]
// Self-checking testbench for the advantage scan unit: directed and random streams of steps.
// A built-in predictor computes each expected word; depends only on gae_pkg and the unit.
`timescale 1ns / 1ps

module gae_advantage_scan_unit_tb;
    import gae_pkg::*;

    localparam int ENV_COUNT    = 64;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 5000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [CFG_ADDR_W-1:0] ADDR_DISCOUNT    = {REG_DISCOUNT, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_TRACE_DECAY = {REG_TRACE_DECAY, 2'b00};

    localparam logic [VAL_W-1:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] Q_NEG_MAX = 32'h8000_0000;
    localparam logic [WGT_W-1:0] WGT_ALL   = 17'h1_FFFF;

    // Wide signed arithmetic so no intermediate product can overflow.
    typedef logic signed [95:0] wide_t;
    localparam wide_t ROUND_HALF = 96'sh8000_0000;
    localparam wide_t CLIP_HI    = 96'sh7FFF_FFFF;
    localparam wide_t CLIP_LO    = -96'sh8000_0000;

    typedef struct {
        logic [ENV_W-1:0] env;
        logic [ACC_W-1:0] advantage;
        logic [ACC_W-1:0] return_target;
        logic             saturated;
    } scan_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: env_index, reward, value_estimate, next_value, bootstrap_weight,
    //        continue_weight (lowest bits first)
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: first_step
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: out_env_index, advantage, return_target, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: saturated
    logic                  m_axis_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: weights as last written and one running advantage per environment.
    logic [WGT_W-1:0] gamma_q16  = DISCOUNT_RESET;
    logic [WGT_W-1:0] lambda_q16 = TRACE_DECAY_RESET;
    logic [ACC_W-1:0] adv_running [ENV_COUNT];

    scan_result_t pending_advantages [$];
    scan_result_t want;

    int mismatches  = 0;
    int quiet_count = 0;
    int sender_idle = 0;
    int sink_stall  = 0;

    gae_advantage_scan_unit #(
        .ENVIRONMENTS(ENV_COUNT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Weights above one count as exactly one.
    function automatic logic [WGT_W-1:0] weight_clamp(input logic [WGT_W-1:0] w);
        return (w > ONE_Q16) ? ONE_Q16 : w;
    endfunction

    // Clip to the signed 32-bit range; the top bit flags a clip.
    function automatic logic [32:0] clip32(input wide_t x);
        if (x > CLIP_HI)
            return {1'b1, Q_POS_MAX};
        if (x < CLIP_LO)
            return {1'b1, Q_NEG_MAX};
        return {1'b0, x[31:0]};
    endfunction

    // Expected result word of one step; also updates the running advantage.
    function automatic scan_result_t predict_advantage(input logic [IN_DATA_W-1:0] word,
                                                       input logic first);
        scan_result_t     r;
        logic [ENV_W-1:0] env;
        wide_t            reward, value, next, gam, lam, bw, cw;
        wide_t            prior, boot, delta, decay, carry;
        logic [32:0]      clipped;
        env    = word[5:0];
        reward = wide_t'($signed(word[37:6]));
        value  = wide_t'($signed(word[69:38]));
        next   = wide_t'($signed(word[101:70]));
        bw     = wide_t'(weight_clamp(word[118:102]));
        cw     = wide_t'(weight_clamp(word[135:119]));
        gam    = wide_t'(weight_clamp(gamma_q16));
        lam    = wide_t'(weight_clamp(lambda_q16));
        prior  = '0;
        if (!first && env < ENV_COUNT)
            prior = wide_t'($signed(adv_running[env]));
        boot    = (next * (gam * bw) + ROUND_HALF) >>> 32;
        delta   = reward + boot - value;
        decay   = (gam * lam * cw + 96'sd32768) >>> 16;
        carry   = (prior * decay + ROUND_HALF) >>> 32;
        clipped = clip32(delta + carry);
        r.env         = env;
        r.advantage   = clipped[31:0];
        r.saturated   = clipped[32];
        if (env < ENV_COUNT)
            adv_running[env] = clipped[31:0];
        clipped = clip32(wide_t'($signed(r.advantage)) + value);
        r.return_target = clipped[31:0];
        r.saturated     = r.saturated | clipped[32];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch in %s at %0t: expected %h, got %h", name, $realtime,
                         exp_v, act_v);
        end
    endtask

    // Monitor: checks result words, predicts accepted steps, tracks register writes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_advantages.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result word at %0t: %h", $realtime, m_axis_tdata);
                end
                else
                begin
                    want = pending_advantages.pop_front();
                    check_field("out_env_index", 32'(want.env), 32'(m_axis_tdata[5:0]));
                    check_field("advantage", want.advantage, m_axis_tdata[37:6]);
                    check_field("return_target", want.return_target, m_axis_tdata[69:38]);
                    check_field("saturated", 32'(want.saturated), 32'(m_axis_tuser));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_advantages.push_back(predict_advantage(s_axis_tdata, s_axis_tuser));
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_DISCOUNT)
                    gamma_q16 = pwdata[WGT_W-1:0];
                else if (paddr == ADDR_TRACE_DECAY)
                    lambda_q16 = pwdata[WGT_W-1:0];
            end
        end
    end

    // Result side backpressure.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end

    // Watchdog on cycles without any accepted word or register access.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready) || !rst_n)
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT)
        begin
            $display("FAIL gae_advantage_scan_unit");
            $finish;
        end
    end

    // Send one step word; tvalid stays high after acceptance unless idling follows.
    task automatic send_step(input logic [ENV_W-1:0] env, input logic first,
                             input logic [VAL_W-1:0] reward, input logic [VAL_W-1:0] value,
                             input logic [VAL_W-1:0] next, input logic [WGT_W-1:0] bw,
                             input logic [WGT_W-1:0] cw);
        while ($urandom_range(99) < sender_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cw, bw, next, value, reward, env};
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_advantages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_and_verify(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [WGT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {15'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("register read back", {15'd0, value}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_weights(input logic [WGT_W-1:0] gam, input logic [WGT_W-1:0] lam);
        write_and_verify(ADDR_DISCOUNT, gam);
        write_and_verify(ADDR_TRACE_DECAY, lam);
    endtask

    // Mostly small values, with the extremes and full-range noise mixed in.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return Q_POS_MAX;
            1:       return Q_NEG_MAX;
            2, 3:    return $urandom;
            default: return $urandom_range(524288) - 32'd262144;
        endcase
    endfunction

    // Often one, sometimes zero, mostly any fraction up to one, sometimes above one.
    function automatic logic [WGT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return '0;
            1, 2, 3: return ONE_Q16;
            4:       return WGT_W'($urandom_range(WGT_ALL));
            default: return WGT_W'($urandom_range(ONE_Q16));
        endcase
    endfunction

    function automatic logic [WGT_W-1:0] pick_decay();
        if ($urandom_range(4) == 0)
            return WGT_W'($urandom_range(WGT_ALL));
        return WGT_W'($urandom_range(55000, ONE_Q16));
    endfunction

    // Field extremes and weight clamping under the reset-time weights.
    task automatic test_field_extremes();
        send_step(6'd0, 1'b1, Q_POS_MAX, 32'd0, 32'd0, '0, '0);
        send_step(6'd63, 1'b1, Q_NEG_MAX, Q_POS_MAX, Q_NEG_MAX, ONE_Q16, ONE_Q16);
        send_step(6'd63, 1'b0, 32'd0, 32'd0, 32'd0, '0, ONE_Q16);
        send_step(6'd42, 1'b1, Q_POS_MAX, Q_NEG_MAX, Q_POS_MAX, WGT_ALL, WGT_ALL);
        send_step(6'd42, 1'b0, Q_POS_MAX, Q_POS_MAX, 32'd0, 17'd65537, 17'd65537);
        send_step(6'd21, 1'b1, 32'h0001_8000, 32'h0000_8000, 32'hFFFF_8000,
                  17'h0AAAA, 17'h15555);
        send_step(6'd21, 1'b0, 32'hFFFE_0000, 32'h0003_4000, 32'h0002_0000,
                  17'h15555, 17'h0AAAA);
        send_step(6'd21, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  ONE_Q16, 17'h0FFFF);
        drain_results();
    endtask

    // Discount and trace decay at zero, at one and above one.
    task automatic test_weight_extremes();
        set_weights('0, '0);
        send_step(6'd3, 1'b1, 32'h0002_0000, 32'h0001_0000, Q_POS_MAX, ONE_Q16, ONE_Q16);
        send_step(6'd3, 1'b0, 32'h0001_0000, 32'd0, 32'h0001_0000, ONE_Q16, ONE_Q16);
        drain_results();
        set_weights(ONE_Q16, ONE_Q16);
        send_step(6'd4, 1'b1, Q_POS_MAX, 32'd0, Q_POS_MAX, ONE_Q16, ONE_Q16);
        send_step(6'd4, 1'b0, 32'd0, 32'd0, 32'd0, '0, ONE_Q16);
        send_step(6'd4, 1'b0, Q_NEG_MAX, Q_POS_MAX, Q_NEG_MAX, ONE_Q16, ONE_Q16);
        drain_results();
        set_weights(WGT_ALL, 17'd65537);
        send_step(6'd5, 1'b1, 32'hFFFF_0000, 32'h0000_4000, 32'h0010_0000, ONE_Q16, ONE_Q16);
        send_step(6'd5, 1'b0, 32'h0000_C000, 32'hFFFF_C000, 32'hFFF0_0000, 17'h18000,
                  17'h18000);
        drain_results();
    endtask

    // Interleaved episodes over a few lanes, with broken sequences as noise.
    task automatic test_random_episodes(input int idle_pct, input int stall_pct,
                                        input int count);
        logic [ENV_W-1:0] lane_env [4];
        int               lane_left [4];
        int               lane;
        logic             first;
        logic [ENV_W-1:0] env;
        logic [WGT_W-1:0] bw;
        lane_left   = '{default: 0};
        lane_env    = '{default: '0};
        set_weights(pick_decay(), pick_decay());
        sender_idle = idle_pct;
        sink_stall  = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            lane = $urandom_range(3);
            bw   = pick_weight();
            if ($urandom_range(9) == 0)
            begin
                env   = ENV_W'($urandom_range(63));
                first = 1'($urandom_range(1));
            end
            else
            begin
                first = (lane_left[lane] == 0);
                if (first)
                begin
                    lane_env[lane]  = $urandom_range(1) ? ENV_W'($urandom_range(63)) :
                                                          ENV_W'($urandom_range(3));
                    lane_left[lane] = $urandom_range(1, 16);
                    if ($urandom_range(1))
                        bw = '0;
                end
                lane_left[lane]--;
                env = lane_env[lane];
            end
            send_step(env, first, pick_value(), pick_value(), pick_value(), bw,
                      pick_weight());
        end
        drain_results();
        sender_idle = 0;
        sink_stall  = 0;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        for (int e = 0; e < ENV_COUNT; e++)
            adv_running[e] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_weight_extremes();
        test_random_episodes(0, 0, 262);
        test_random_episodes(74, 0, 262);
        test_random_episodes(0, 74, 262);
        test_random_episodes(26, 26, 262);

        if (mismatches == 0)
            $display("PASS gae_advantage_scan_unit");
        else
            $display("FAIL gae_advantage_scan_unit");
        $finish;
    end

endmodule

[filelist.f]
design/gae_pkg.sv
design/gae_cfg_regs.sv
design/gae_acc_mem.sv
design/gae_scan_pipe.sv
design/gae_advantage_scan_unit.sv
design/gae_scan_checker.sv
tb/gae_advantage_scan_unit_tb.sv
